>>> hdl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// shared sizes, operation and status codes, and the per-cell command beat
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    // signed compare width, wide enough for an 8-bit position and the count
    localparam int CMP_W   = CNT_W + 8;
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 40;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ     = 3'd0,
        KIND_INS_HEAD = 3'd1,
        KIND_INS_TAIL = 3'd2,
        KIND_INS_AT   = 3'd3,
        KIND_DELETE   = 3'd4
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] sel;
        logic [VAL_W-1:0] value;
    } t_cell_op;

endpackage

>>> hdl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// ordered list of signed 32-bit values in a chain of shifting cells
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata fields (lsb up)                     | width
//  ---------+-----+-------------------------------------------+------
//  s_axis   | in  | kind[2:0] position[10:3] value[42:11]     | 48
//  m_axis   | out | read_value[31:0] status[33:32]            | 40
//
//  one operation per cycle while the input is ready: every cell updates in the
//  accepting cycle, an insert or delete moves every cell from its slot on by one at once
//  the result beat is registered in the output register on acceptance
//  the input is ready whenever the output register is empty or being taken
//  reset clears the count and the output valid; cell contents stay undefined
//
module indexed_list_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // kind, position, value, zero pad
    input  logic [ils_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // read_value, status, zero pad
    output logic [ils_pkg::OUT_W-1:0]  o_m_axis_tdata
);
    import ils_pkg::*;

    // input beat fields
    logic [KIND_W-1:0]        in_kind;
    logic [POS_W-1:0]         in_pos;
    logic [VAL_W-1:0]         in_value;
    logic                     s_acc;

    // control state
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    logic [VAL_W-1:0]         r_read_value;
    logic [STAT_W-1:0]        r_status;
    logic [VAL_W-1:0]         n_read_value;
    logic [STAT_W-1:0]        n_status;

    // decode
    logic signed [CMP_W-1:0]  pos_s;
    logic signed [CMP_W-1:0]  cnt_s;
    logic signed [CMP_W-1:0]  ins_pos;
    logic                     pos_in_range;
    logic                     is_insert;
    t_cell_op                 cell_op;

    // chain wiring
    logic [VAL_W-1:0]         cell_val [DEPTH];
    logic [VAL_W-1:0]         cell_rd  [DEPTH];
    logic [VAL_W-1:0]         rd_bus;

    assign in_kind  = i_s_axis_tdata[KIND_W-1:0];
    assign in_pos   = i_s_axis_tdata[KIND_W+POS_W-1:KIND_W];
    assign in_value = i_s_axis_tdata[KIND_W+POS_W+VAL_W-1:KIND_W+POS_W];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // sign-extend the position, zero-extend the count, compare signed
    assign pos_s = {{(CMP_W-POS_W){in_pos[POS_W-1]}}, in_pos};
    assign cnt_s = {{(CMP_W-CNT_W){1'b0}}, r_count};
    assign pos_in_range = (pos_s >= 0) && (pos_s < cnt_s);

    // or of masked cell outputs; only the selected cell drives nonzero
    always_comb begin
        rd_bus = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_bus = rd_bus | cell_rd[i];
        end
    end

    always_comb begin
        cell_op       = '0;
        cell_op.value = in_value;
        cell_op.sel   = pos_s[IDX_W-1:0];
        n_count       = r_count;
        n_read_value  = '0;
        n_status      = ST_DONE;
        is_insert     = 1'b0;
        ins_pos       = pos_s;

        unique case (in_kind)
            KIND_READ: begin
                if (pos_in_range) begin
                    n_read_value = rd_bus;
                end else begin
                    n_read_value = '1;
                    n_status     = ST_RANGE;
                end
            end
            KIND_INS_HEAD: begin
                is_insert = 1'b1;
                ins_pos   = '0;
            end
            KIND_INS_TAIL: begin
                is_insert = 1'b1;
                ins_pos   = cnt_s;
            end
            KIND_INS_AT: begin
                is_insert = 1'b1;
                ins_pos   = pos_s;
            end
            KIND_DELETE: begin
                if (pos_in_range) begin
                    cell_op.del = s_acc;
                    n_count     = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                // unknown kinds leave everything as it is
            end
        endcase

        // range test comes before the full test
        if (is_insert) begin
            priority if (ins_pos > cnt_s) begin
                n_status = ST_RANGE;
            end else if (r_count == CNT_W'(DEPTH)) begin
                n_status = ST_FULL;
            end else begin
                cell_op.ins = s_acc;
                cell_op.sel = (ins_pos <= 0) ? '0 : ins_pos[IDX_W-1:0];
                n_count     = r_count + CNT_W'(1);
            end
        end
    end

    // row of cells, each taking its neighbor on a shift
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] left_val;
        logic [VAL_W-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_val = cell_val[g];
        end else begin : g_mid_r
            assign right_val = cell_val[g+1];
        end

        ils_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_index (IDX_W'(g)),
            .i_left  (left_val),
            .i_right (right_val),
            .o_value (cell_val[g]),
            .o_read  (cell_rd[g])
        );
    end

    // count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_W-VAL_W-STAT_W){1'b0}}, r_status, r_read_value};

    // count never runs past the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count above depth");

    // a pending full result means the store really is full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_FULL)) |-> (r_count == CNT_W'(DEPTH)))
        else $error("full status with room left");

    // count moves only on an accepted beat, and by one at most
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
            ($past(s_acc) &&
             ((r_count == $past(r_count) + CNT_W'(1)) ||
              (r_count == $past(r_count) - CNT_W'(1)))))
        else $error("count changed without an accepted beat");

endmodule

>>> hdl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell
// one list slot: holds a value, takes its left or right neighbor on a shift
// ----------------------------------------------------------------------------
module ils_cell (
    input  logic                       i_clk,
    input  ils_pkg::t_cell_op          i_op,
    input  logic [ils_pkg::IDX_W-1:0]  i_index,
    input  logic [ils_pkg::VAL_W-1:0]  i_left,
    input  logic [ils_pkg::VAL_W-1:0]  i_right,
    output logic [ils_pkg::VAL_W-1:0]  o_value,
    output logic [ils_pkg::VAL_W-1:0]  o_read
);
    import ils_pkg::*;

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_op.ins) begin
            if (i_index == i_op.sel) begin
                n_value = i_op.value;
            end else if (i_index > i_op.sel) begin
                n_value = i_left;
            end
        end else if (i_op.del) begin
            if (i_index >= i_op.sel) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    // masked value for the shared read bus
    assign o_read  = (i_index == i_op.sel) ? r_value : '0;

endmodule
